/* sv/gmpd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmpd_pkg
// Shared types, codes and constants for the grid MIDI packet decoder.
// ----------------------------------------------------------------------------
package gmpd_pkg;

  typedef logic [3:0] cin_t;
  typedef logic [7:0] byte_t;
  typedef logic [3:0] pos_t;
  typedef logic [2:0] layout_t;
  typedef logic [2:0] colour_t;
  typedef logic [1:0] chan_t;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_LED    = 2'd1,
    ACT_LAYOUT = 2'd2,
    ACT_REPLY  = 2'd3
  } action_t;

  // code index numbers
  localparam cin_t CIN_SYSEX      = 4'd4;
  localparam cin_t CIN_SYSEX_END1 = 4'd5;
  localparam cin_t CIN_SYSEX_END2 = 4'd6;
  localparam cin_t CIN_SYSEX_END3 = 4'd7;
  localparam cin_t CIN_NOTE_OFF   = 4'd8;
  localparam cin_t CIN_NOTE_ON    = 4'd9;
  localparam cin_t CIN_CTRL       = 4'd11;

  // sysex assembly
  localparam int SYSEX_LIMIT = 64;
  localparam int LEN_W       = 7;
  localparam int KEPT_BYTES  = 8;
  localparam int KEPT_IDX_W  = $clog2(KEPT_BYTES);
  localparam logic [47:0] SYSEX_HDR    = 48'hF0_00_20_29_02_18;
  localparam byte_t       CMD_LAYOUT    = 8'h22;
  localparam byte_t       CMD_CHALLENGE = 8'h40;
  localparam byte_t       NUM_LAYOUTS   = 8'd6;
  localparam layout_t     LAYOUT_DRUM   = 3'd1;

  // control row
  localparam logic [4:0] CTRL_BLOCK = 5'd13;  // controls 104..111
  localparam pos_t       CTRL_ROW_X = 4'd9;

  // layout indicator LED
  localparam pos_t  IND_X     = 4'd9;
  localparam pos_t  IND_Y     = 4'd4;
  localparam byte_t IND_LEVEL = 8'd64;

  typedef struct packed {
    logic hit;
    pos_t x;
    pos_t y;
  } led_res_t;

  typedef struct packed {
    action_t action;
    layout_t layout;
    colour_t colour;
  } sx_res_t;

  // indicator colour per layout: bit0 red, bit1 green, bit2 blue
  function automatic colour_t layout_colour(input layout_t lay);
    colour_t c;
    case (lay)
      3'd0:    c = 3'd1;
      3'd1:    c = 3'd2;
      3'd2:    c = 3'd4;
      3'd3:    c = 3'd3;
      3'd4:    c = 3'd6;
      3'd5:    c = 3'd5;
      default: c = 3'd0;
    endcase
    return c;
  endfunction

endpackage

/* sv/gmpd_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmpd_if
// Valid/ready channels for packets in, actions out and the config write.
// ----------------------------------------------------------------------------
interface gmpd_in_if;
  logic                valid;
  logic                ready;
  gmpd_pkg::cin_t      code_index;
  gmpd_pkg::byte_t     status_byte;
  gmpd_pkg::byte_t     first_data_byte;
  gmpd_pkg::byte_t     second_data_byte;

  modport source (output valid, code_index, status_byte, first_data_byte,
                  second_data_byte, input ready);
  modport sink   (input valid, code_index, status_byte, first_data_byte,
                  second_data_byte, output ready);
endinterface

interface gmpd_out_if;
  logic                valid;
  logic                ready;
  gmpd_pkg::action_t   action;
  gmpd_pkg::pos_t      led_x;
  gmpd_pkg::pos_t      led_y;
  gmpd_pkg::byte_t     led_level;
  gmpd_pkg::chan_t     colour_channel;
  gmpd_pkg::layout_t   new_layout;
  gmpd_pkg::colour_t   indicator_colour;

  modport source (output valid, action, led_x, led_y, led_level, colour_channel,
                  new_layout, indicator_colour, input ready);
  modport sink   (input valid, action, led_x, led_y, led_level, colour_channel,
                  new_layout, indicator_colour, output ready);
endinterface

interface gmpd_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* sv/gmpd_note_map.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmpd_note_map
// Maps a note number to a grid LED position for the drum or digit layout.
// ----------------------------------------------------------------------------
module gmpd_note_map (
  input  gmpd_pkg::byte_t    note,
  input  gmpd_pkg::layout_t  layout,
  output gmpd_pkg::led_res_t res
);
  import gmpd_pkg::*;

  byte_t        d_lo;
  byte_t        d_hi;
  byte_t        d_side;
  logic [15:0]  prod;
  logic [4:0]   q;
  byte_t        q10;
  byte_t        rem;

  assign d_lo   = note - 8'd36;
  assign d_hi   = note - 8'd68;
  assign d_side = 8'd107 - note;

  // note / 10 by reciprocal, exact for all 8-bit notes
  assign prod = {8'd0, note} * 16'd205;
  assign q    = prod[15:11];
  assign q10  = {3'd0, q} * 8'd10;
  assign rem  = note - q10;

  always_comb begin
    res = '0;
    if (layout == LAYOUT_DRUM) begin
      if (note >= 8'd36 && note <= 8'd107) begin
        res.hit = 1'b1;
        if (note <= 8'd67) begin
          res.x = {2'b00, note[1:0]};
          res.y = {1'b0, d_lo[4:2]};
        end else if (note <= 8'd99) begin
          res.x = {2'b01, note[1:0]};
          res.y = {1'b0, d_hi[4:2]};
        end else begin
          res.x = 4'd8;
          res.y = d_side[3:0];
        end
      end
    end else begin
      if (note >= 8'd11 && note <= 8'd89 && rem != 8'd0) begin
        res.hit = 1'b1;
        res.x   = rem[3:0] - 4'd1;
        res.y   = q[3:0] - 4'd1;
      end
    end
  end

endmodule

/* sv/gmpd_sysex.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmpd_sysex
// SysEx assembly buffer, message check on end packets and the layout register.
// ----------------------------------------------------------------------------
module gmpd_sysex (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  gmpd_pkg::cin_t     cin,
  input  gmpd_pkg::byte_t    b0,
  input  gmpd_pkg::byte_t    b1,
  input  gmpd_pkg::byte_t    b2,
  output gmpd_pkg::sx_res_t  res,
  output gmpd_pkg::layout_t  layout
);
  import gmpd_pkg::*;

  byte_t             bytes_r   [KEPT_BYTES];
  byte_t             bytes_nxt [KEPT_BYTES];
  logic [LEN_W-1:0]  len_r;
  logic [LEN_W-1:0]  len_nxt;
  logic [LEN_W-1:0]  len_add;
  layout_t           layout_r;
  logic              is_cont;
  logic              is_end;
  logic [1:0]        n_bytes;
  byte_t             pkt [3];
  logic              hdr_ok;

  assign is_cont = (cin == CIN_SYSEX);
  assign is_end  = (cin == CIN_SYSEX_END1) || (cin == CIN_SYSEX_END2) ||
                   (cin == CIN_SYSEX_END3);
  assign n_bytes = is_cont ? 2'd3 : (cin[1:0] - 2'd0);
  assign len_add = len_r + {{(LEN_W-2){1'b0}}, n_bytes};

  assign pkt[0] = b0;
  assign pkt[1] = b1;
  assign pkt[2] = b2;

  // each kept entry takes the packet byte that lands on its position
  always_comb begin
    for (int i = 0; i < KEPT_BYTES; i++) begin
      bytes_nxt[i] = bytes_r[i];
      for (int k = 0; k < 3; k++) begin
        if (k < int'(n_bytes) &&
            (len_r + LEN_W'(k)) == LEN_W'(i)) begin
          bytes_nxt[i] = pkt[k];
        end
      end
    end
  end

  assign hdr_ok = ({bytes_nxt[0], bytes_nxt[1], bytes_nxt[2],
                    bytes_nxt[3], bytes_nxt[4], bytes_nxt[5]} == SYSEX_HDR);

  always_comb begin
    res = '0;
    if (is_end && len_add > LEN_W'(KEPT_BYTES - 1) && hdr_ok) begin
      if (bytes_nxt[6] == CMD_LAYOUT) begin
        if (bytes_nxt[7] < NUM_LAYOUTS) begin
          res.action = ACT_LAYOUT;
          res.layout = bytes_nxt[7][2:0];
          res.colour = layout_colour(bytes_nxt[7][2:0]);
        end
      end else if (bytes_nxt[6] == CMD_CHALLENGE) begin
        res.action = ACT_REPLY;
      end
    end
  end

  always_comb begin
    len_nxt = len_r;
    if (is_cont) begin
      len_nxt = (len_add >= LEN_W'(SYSEX_LIMIT)) ? '0 : len_add;
    end else if (is_end) begin
      len_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= '0;
      layout_r <= '0;
    end else if (fire) begin
      len_r <= len_nxt;
      if (res.action == ACT_LAYOUT) begin
        layout_r <= res.layout;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && (is_cont || is_end)) begin
      bytes_r <= bytes_nxt;
    end
  end

  assign layout = layout_r;

`ifndef SYNTH
  a_len_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    len_r < LEN_W'(SYSEX_LIMIT))
    else $error("sysex length reached limit");

  a_end_clears_len: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && is_end) |=> (len_r == '0))
    else $error("sysex length not cleared after end packet");
`endif

endmodule

/* sv/grid_midi_packet_decoder_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_midi_packet_decoder_unit
// Decodes USB-MIDI event packets into LED grid actions.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  : one 32-bit USB-MIDI event packet per transaction.
//   out_if : exactly one action per packet, in packet order.
//   cfg_if : writes top_row_map; always ready, write only while idle.
// Path: an accepted packet passes the input register, the decode and the
//   result register before its action appears on out_if.
// Throughput: one packet per cycle while out_if is not stalled; the decode
//   is a single registered pass and the layout/sysex state updates as a
//   packet moves to the result register, so the next packet already sees it.
// Stall: when out_if.ready is low the result register holds, the input
//   register fills, and in_if.ready drops only when both are occupied.
// Reset (rst_n low, synchronous): both stages empty, layout 0 (session),
//   sysex length 0, top_row_map 0. Sysex bytes are not cleared.
// ----------------------------------------------------------------------------
module grid_midi_packet_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  gmpd_in_if.sink     in_if,
  gmpd_out_if.source  out_if,
  gmpd_cfg_if.sink    cfg_if
);
  import gmpd_pkg::*;

  logic      s1_valid_r;
  cin_t      s1_cin_r;
  byte_t     s1_b0_r;
  byte_t     s1_b1_r;
  byte_t     s1_b2_r;
  logic      s1_adv;
  logic      in_fire;
  logic [31:0] map_r;

  led_res_t  note_res;
  sx_res_t   sx_res;
  layout_t   layout;

  logic      out_valid_r;
  action_t   act_r,   act_nxt;
  pos_t      x_r,     x_nxt;
  pos_t      y_r,     y_nxt;
  byte_t     lvl_r,   lvl_nxt;
  chan_t     chan_r,  chan_nxt;
  layout_t   lay_r,   lay_nxt;
  colour_t   col_r,   col_nxt;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cin_r <= in_if.code_index;
      s1_b0_r  <= in_if.status_byte;
      s1_b1_r  <= in_if.first_data_byte;
      s1_b2_r  <= in_if.second_data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r <= '0;
    end else if (cfg_if.valid) begin
      map_r <= cfg_if.data;
    end
  end

  gmpd_note_map u_note_map (
    .note   (s1_b1_r),
    .layout (layout),
    .res    (note_res)
  );

  gmpd_sysex u_sysex (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (s1_adv),
    .cin    (s1_cin_r),
    .b0     (s1_b0_r),
    .b1     (s1_b1_r),
    .b2     (s1_b2_r),
    .res    (sx_res),
    .layout (layout)
  );

  always_comb begin
    act_nxt  = ACT_NONE;
    x_nxt    = '0;
    y_nxt    = '0;
    lvl_nxt  = '0;
    chan_nxt = '0;
    lay_nxt  = '0;
    col_nxt  = '0;
    case (s1_cin_r)
      CIN_NOTE_ON, CIN_NOTE_OFF: begin
        if (note_res.hit) begin
          act_nxt  = ACT_LED;
          x_nxt    = note_res.x;
          y_nxt    = note_res.y;
          lvl_nxt  = (s1_cin_r == CIN_NOTE_ON) ? s1_b2_r : 8'd0;
          // channels above 2 fall back to channel 0
          chan_nxt = (s1_b0_r[3:0] > 4'd2) ? 2'd0 : s1_b0_r[1:0];
        end
      end
      CIN_CTRL: begin
        if (s1_b1_r[7:3] == CTRL_BLOCK) begin
          act_nxt = ACT_LED;
          x_nxt   = CTRL_ROW_X;
          y_nxt   = map_r[{s1_b1_r[2:0], 2'b00} +: 4];
          lvl_nxt = s1_b2_r;
        end
      end
      CIN_SYSEX_END1, CIN_SYSEX_END2, CIN_SYSEX_END3: begin
        act_nxt = sx_res.action;
        if (sx_res.action == ACT_LAYOUT) begin
          x_nxt   = IND_X;
          y_nxt   = IND_Y;
          lvl_nxt = IND_LEVEL;
          lay_nxt = sx_res.layout;
          col_nxt = sx_res.colour;
        end
      end
      default: begin
        act_nxt = ACT_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      act_r  <= act_nxt;
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      lvl_r  <= lvl_nxt;
      chan_r <= chan_nxt;
      lay_r  <= lay_nxt;
      col_r  <= col_nxt;
    end
  end

  assign out_if.valid            = out_valid_r;
  assign out_if.action           = act_r;
  assign out_if.led_x            = x_r;
  assign out_if.led_y            = y_r;
  assign out_if.led_level        = lvl_r;
  assign out_if.colour_channel   = chan_r;
  assign out_if.new_layout       = lay_r;
  assign out_if.indicator_colour = col_r;

`ifndef SYNTH
  a_layout_follows_action: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && act_nxt == ACT_LAYOUT) |=> (layout == out_if.new_layout))
    else $error("layout register does not match reported layout");

  a_s1_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_cin_r) &&
                                 $stable(s1_b1_r)))
    else $error("input stage lost a transaction while stalled");

  a_out_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_if.ready) |=> (out_valid_r && $stable(act_r)))
    else $error("result register changed while stalled");
`endif

endmodule

/* tb/gmpd_action_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmpd_action_checker
// Watches the packet, action and config channels of the grid MIDI packet
// decoder. Each accepted packet is decoded by an independent model of the
// note, control and sysex handling, and the result is queued. Each accepted
// action is compared field by field against the oldest queued result.
// ----------------------------------------------------------------------------
module gmpd_action_checker (
  input  logic clk,
  input  logic rst_n,
  gmpd_in_if   in_mon,
  gmpd_out_if  out_mon,
  gmpd_cfg_if  cfg_mon,
  output int   error_count,
  output int   pending,
  output int   packets_seen,
  output int   led_count,
  output int   layout_count,
  output int   reply_count
);
  import gmpd_pkg::*;

  typedef struct packed {
    action_t action;
    pos_t    x;
    pos_t    y;
    byte_t   level;
    chan_t   chan;
    layout_t layout;
    colour_t colour;
  } grid_action_t;

  localparam colour_t RED   = 3'b001;
  localparam colour_t GREEN = 3'b010;
  localparam colour_t BLUE  = 3'b100;
  // session, user 1, user 2, reserved, volume, pan
  localparam colour_t IND_COLOUR [0:5] = '{RED, GREEN, BLUE, RED | GREEN,
                                           GREEN | BLUE, RED | BLUE};
  localparam int REPORT_MAX = 10;

  layout_t      cur_layout;
  byte_t        sx_kept [KEPT_BYTES];
  int           sx_len;
  logic [31:0]  row_map;
  grid_action_t expected_q [$];

  function automatic grid_action_t map_note(input byte_t status, input byte_t note,
                                            input byte_t level);
    grid_action_t r;
    int n;
    int x;
    int y;
    bit hit;
    r   = '0;
    n   = note;
    hit = 1'b0;
    x   = 0;
    y   = 0;
    if (cur_layout == LAYOUT_DRUM) begin
      // two 4-wide blocks of 8 rows, then a side column counting down
      if (n >= 36 && n <= 67) begin
        hit = 1'b1; x = n % 4;     y = (n - 36) / 4;
      end else if (n >= 68 && n <= 99) begin
        hit = 1'b1; x = n % 4 + 4; y = (n - 68) / 4;
      end else if (n >= 100 && n <= 107) begin
        hit = 1'b1; x = 8;         y = 107 - n;
      end
    end else if (n >= 11 && n <= 89 && n % 10 != 0) begin
      hit = 1'b1;
      x   = n % 10 - 1;
      y   = n / 10 - 1;
    end
    if (hit) begin
      r.action = ACT_LED;
      r.x      = pos_t'(x);
      r.y      = pos_t'(y);
      r.level  = level;
      r.chan   = (status[3:0] > 4'd2) ? chan_t'(0) : status[1:0];
    end
    return r;
  endfunction

  function automatic grid_action_t map_control(input byte_t ctl, input byte_t value);
    grid_action_t r;
    int k;
    r = '0;
    if (ctl >= 8'd104 && ctl <= 8'd111) begin
      k        = ctl - 104;
      r.action = ACT_LED;
      r.x      = CTRL_ROW_X;
      r.y      = row_map[4 * k +: 4];
      r.level  = value;
    end
    return r;
  endfunction

  function automatic void push_sysex(input byte_t b);
    if (sx_len < KEPT_BYTES)
      sx_kept[sx_len] = b;
    sx_len = (sx_len + 1) & 'h7F;
  endfunction

  function automatic grid_action_t close_sysex();
    grid_action_t r;
    bit hdr_ok;
    r      = '0;
    hdr_ok = 1'b1;
    if (sx_len >= KEPT_BYTES) begin
      for (int i = 0; i < 6; i++)
        if (sx_kept[i] != SYSEX_HDR[47 - 8 * i -: 8])
          hdr_ok = 1'b0;
      if (hdr_ok && sx_kept[6] == CMD_LAYOUT) begin
        if (sx_kept[7] < NUM_LAYOUTS) begin
          cur_layout = layout_t'(sx_kept[7]);
          r.action   = ACT_LAYOUT;
          r.x        = IND_X;
          r.y        = IND_Y;
          r.level    = IND_LEVEL;
          r.layout   = cur_layout;
          r.colour   = IND_COLOUR[cur_layout];
        end
      end else if (hdr_ok && sx_kept[6] == CMD_CHALLENGE) begin
        r.action = ACT_REPLY;
      end
    end
    return r;
  endfunction

  function automatic grid_action_t decode_packet(input cin_t c, input byte_t s,
                                                 input byte_t d1, input byte_t d2);
    grid_action_t r;
    r = '0;
    case (c)
      CIN_NOTE_ON:  r = map_note(s, d1, d2);
      CIN_NOTE_OFF: r = map_note(s, d1, 8'd0);
      CIN_CTRL:     r = map_control(d1, d2);
      CIN_SYSEX: begin
        push_sysex(s);
        push_sysex(d1);
        push_sysex(d2);
        if (sx_len >= SYSEX_LIMIT)
          sx_len = 0;  // overlong message dropped
      end
      CIN_SYSEX_END1, CIN_SYSEX_END2, CIN_SYSEX_END3: begin
        push_sysex(s);
        if (c != CIN_SYSEX_END1)
          push_sysex(d1);
        if (c == CIN_SYSEX_END3)
          push_sysex(d2);
        r      = close_sysex();
        sx_len = 0;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    grid_action_t got;
    grid_action_t want;
    if (!rst_n) begin
      cur_layout   = '0;
      sx_len       = 0;
      row_map      = '0;
      expected_q.delete();
      error_count  = 0;
      packets_seen = 0;
      led_count    = 0;
      layout_count = 0;
      reply_count  = 0;
      pending     <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready)
        row_map = cfg_mon.data;

      // retire the oldest expectation before queuing this edge's packet
      if (out_mon.valid && out_mon.ready) begin
        got.action = out_mon.action;
        got.x      = out_mon.led_x;
        got.y      = out_mon.led_y;
        got.level  = out_mon.led_level;
        got.chan   = out_mon.colour_channel;
        got.layout = out_mon.new_layout;
        got.colour = out_mon.indicator_colour;
        case (got.action)
          ACT_LED:    led_count++;
          ACT_LAYOUT: layout_count++;
          ACT_REPLY:  reply_count++;
          default: ;
        endcase
        if (expected_q.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_MAX)
            $display("%0t: unexpected action transaction act=%0d x=%0d y=%0d",
                     $time, got.action, got.x, got.y);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            error_count++;
            if (error_count <= REPORT_MAX)
              $display({"%0t: action mismatch\n",
                        "  expected act=%0d x=%0d y=%0d lvl=%0d ch=%0d lay=%0d col=%0d\n",
                        "  actual   act=%0d x=%0d y=%0d lvl=%0d ch=%0d lay=%0d col=%0d"},
                       $time,
                       want.action, want.x, want.y, want.level, want.chan,
                       want.layout, want.colour,
                       got.action, got.x, got.y, got.level, got.chan,
                       got.layout, got.colour);
          end
        end
      end

      if (in_mon.valid && in_mon.ready) begin
        expected_q.push_back(decode_packet(in_mon.code_index, in_mon.status_byte,
                                           in_mon.first_data_byte,
                                           in_mon.second_data_byte));
        packets_seen++;
      end

      pending <= expected_q.size();
    end
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the grid MIDI packet decoder. A directed pass hits
// the map corners and special packets, then random phases mix notes,
// controls, well-formed and broken sysex messages under different idle and
// stall patterns, with a new row map written between phases.
// ----------------------------------------------------------------------------
module tb_top;
  import gmpd_pkg::*;

  typedef byte_t msg_t [$];

  // code indexes the decoder does not act on
  localparam cin_t  CIN_MISC_FUNC   = 4'd0;
  localparam cin_t  CIN_SINGLE_BYTE = 4'd15;
  localparam byte_t SYSEX_EOX       = 8'hF7;
  localparam int    PHASE_PACKETS   = 370;
  localparam int    HOLD_CYCLES     = 300;
  localparam int    STUCK_LIMIT     = 2000;

  logic clk;
  logic rst_n;

  gmpd_in_if  in_if ();
  gmpd_out_if out_if ();
  gmpd_cfg_if cfg_if ();

  int error_count;
  int pending;
  int packets_seen;
  int led_count;
  int layout_count;
  int reply_count;

  int tx_idle_pct;
  int rx_stall_pct = 0;
  int hold_seq     = 0;
  int packets_used = 0;
  int stuck_cycles = 0;

  grid_midi_packet_decoder_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  gmpd_action_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_if),
    .out_mon      (out_if),
    .cfg_mon      (cfg_if),
    .error_count  (error_count),
    .pending      (pending),
    .packets_seen (packets_seen),
    .led_count    (led_count),
    .layout_count (layout_count),
    .reply_count  (reply_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // action receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic send_packet(input cin_t c, input byte_t s, input byte_t d1,
                             input byte_t d2);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid            <= 1'b1;
    in_if.code_index       <= c;
    in_if.status_byte      <= s;
    in_if.first_data_byte  <= d1;
    in_if.second_data_byte <= d2;
    do @(posedge clk); while (!in_if.ready);
    if ((c >= CIN_SYSEX && c <= CIN_NOTE_ON) || c == CIN_CTRL)
      packets_used++;
  endtask

  // split a message into 3-byte packets and one closing packet
  task automatic send_sysex(input msg_t m);
    int i;
    i = 0;
    while (m.size() - i > 3) begin
      send_packet(CIN_SYSEX, m[i], m[i + 1], m[i + 2]);
      i += 3;
    end
    case (m.size() - i)
      1:       send_packet(CIN_SYSEX_END1, m[i], byte_t'($urandom_range(255)),
                           byte_t'($urandom_range(255)));
      2:       send_packet(CIN_SYSEX_END2, m[i], m[i + 1], byte_t'($urandom_range(255)));
      default: send_packet(CIN_SYSEX_END3, m[i], m[i + 1], m[i + 2]);
    endcase
  endtask

  function automatic msg_t layout_msg(input byte_t cmd, input byte_t arg);
    msg_t m;
    for (int i = 0; i < 6; i++)
      m.push_back(SYSEX_HDR[47 - 8 * i -: 8]);
    m.push_back(cmd);
    m.push_back(arg);
    return m;
  endfunction

  function automatic msg_t random_command_msg();
    msg_t  m;
    byte_t cmd;
    byte_t arg;
    int    pick;
    pick = $urandom_range(9);
    if (pick < 6)
      cmd = CMD_LAYOUT;
    else if (pick < 8)
      cmd = CMD_CHALLENGE;
    else
      cmd = byte_t'($urandom_range(255));
    arg = ($urandom_range(3) == 0) ? byte_t'($urandom_range(255))
                                   : byte_t'($urandom_range(NUM_LAYOUTS - 1));
    m = layout_msg(cmd, arg);
    if ($urandom_range(9) == 0)
      m[$urandom_range(5)] ^= byte_t'($urandom_range(1, 255));
    repeat ($urandom_range(3))
      m.push_back(byte_t'($urandom_range(255)));
    if ($urandom_range(1))
      m.push_back(SYSEX_EOX);
    return m;
  endfunction

  task automatic random_step();
    msg_t  m;
    int    pick;
    byte_t status;
    byte_t num;
    pick   = $urandom_range(99);
    status = byte_t'($urandom_range(255));
    if ($urandom_range(1))
      status[3:0] = 4'($urandom_range(2));
    if (pick < 40) begin
      num = ($urandom_range(9) < 7) ? byte_t'($urandom_range(11, 107))
                                    : byte_t'($urandom_range(255));
      send_packet($urandom_range(1) ? CIN_NOTE_ON : CIN_NOTE_OFF, status, num,
                  byte_t'($urandom_range(255)));
    end else if (pick < 60) begin
      num = ($urandom_range(3) != 0) ? byte_t'($urandom_range(104, 111))
                                     : byte_t'($urandom_range(255));
      send_packet(CIN_CTRL, status, num, byte_t'($urandom_range(255)));
    end else if (pick < 80) begin
      send_sysex(random_command_msg());
    end else if (pick < 85) begin
      // truncated before the command is complete
      m = random_command_msg();
      while (m.size() > $urandom_range(1, 7))
        void'(m.pop_back());
      send_sysex(m);
    end else if (pick < 88) begin
      // may be long enough to hit the length limit somewhere inside
      repeat ($urandom_range(62, 75))
        m.push_back(byte_t'($urandom_range(255)));
      send_sysex(m);
    end else begin
      send_packet(cin_t'($urandom_range(15)), byte_t'($urandom_range(255)),
                  byte_t'($urandom_range(255)), byte_t'($urandom_range(255)));
    end
  endtask

  task automatic write_row_map(input logic [31:0] map);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= map;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic wait_drain();
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin : stimulus
    int target;
    rst_n                  <= 1'b0;
    in_if.valid            <= 1'b0;
    in_if.code_index       <= '0;
    in_if.status_byte      <= '0;
    in_if.first_data_byte  <= '0;
    in_if.second_data_byte <= '0;
    cfg_if.valid           <= 1'b0;
    cfg_if.data            <= '0;
    tx_idle_pct = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed pass, session layout at start
    write_row_map(32'h8765_4321);
    send_packet(CIN_NOTE_ON,  8'h90, 8'd11,  8'd127);
    send_packet(CIN_NOTE_ON,  8'h92, 8'd89,  8'd1);
    send_packet(CIN_NOTE_ON,  8'h90, 8'd10,  8'd64);   // below the digit map
    send_packet(CIN_NOTE_ON,  8'h91, 8'd20,  8'd64);   // no column for digit 0
    send_packet(CIN_NOTE_OFF, 8'h8F, 8'd45,  8'd200);  // channel clamped, level 0
    send_packet(CIN_CTRL,     8'hB0, 8'd104, 8'd0);
    send_packet(CIN_CTRL,     8'hB5, 8'd111, 8'd255);
    send_packet(CIN_CTRL,     8'hB0, 8'd103, 8'd9);    // outside the control row
    send_packet(CIN_MISC_FUNC,   8'hFF, 8'hFF, 8'hFF);
    send_packet(CIN_SINGLE_BYTE, 8'h00, 8'h00, 8'h00);
    send_packet(CIN_SYSEX_END3, 8'hF0, 8'h7E, SYSEX_EOX);  // too short to check
    send_sysex(layout_msg(CMD_LAYOUT, byte_t'(LAYOUT_DRUM)));
    send_packet(CIN_NOTE_ON, 8'h90, 8'd36,  8'd10);
    send_packet(CIN_NOTE_ON, 8'h91, 8'd107, 8'd20);
    send_packet(CIN_NOTE_ON, 8'h92, 8'd68,  8'd30);
    send_packet(CIN_NOTE_ON, 8'h90, 8'd108, 8'd40);    // above the drum map
    send_sysex(layout_msg(CMD_LAYOUT, 8'd7));           // bad layout, kept
    send_sysex(layout_msg(CMD_CHALLENGE, SYSEX_EOX));
    in_if.valid <= 1'b0;

    for (int p = 0; p < 5; p++) begin
      wait_drain();
      case (p)
        0: begin write_row_map(32'hFFFF_FFFF); tx_idle_pct = 0;  rx_stall_pct <= 0;  end
        1: begin write_row_map(32'h0000_0000); tx_idle_pct = 54; rx_stall_pct <= 0;  end
        2: begin write_row_map($urandom);      tx_idle_pct = 0;  rx_stall_pct <= 54; end
        3: begin write_row_map($urandom);      tx_idle_pct = 8;  rx_stall_pct <= 8;  end
        default: begin
          // receiver goes quiet while packets keep coming
          write_row_map($urandom);
          tx_idle_pct = 0;
          rx_stall_pct <= 0;
          hold_seq     <= hold_seq + 1;
        end
      endcase
      target = packets_used + PHASE_PACKETS;
      while (packets_used < target)
        random_step();
      in_if.valid <= 1'b0;
    end

    wait_drain();
    repeat (6) @(posedge clk);
    $display("%0d packets decoded over a directed pass and five random phases",
             packets_seen);
    $display("actions: %0d LED, %0d layout, %0d reply; receiver held off for %0d cycles",
             led_count, layout_count, reply_count, HOLD_CYCLES);
    if (error_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
